// ===== rtl/deqs_pkg.sv =====
// deqs_pkg: shared types and codes for the deque with search
// request and response payloads, opcodes, status codes, controller/datapath links
// no dependencies
package deqs_pkg;

    localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [3:0] OP_POP_BACK   = 4'd1;
    localparam logic [3:0] OP_PUSH_FRONT = 4'd2;
    localparam logic [3:0] OP_POP_FRONT  = 4'd3;
    localparam logic [3:0] OP_PEEK_BACK  = 4'd4;
    localparam logic [3:0] OP_PEEK_FRONT = 4'd5;
    localparam logic [3:0] OP_SEARCH     = 4'd6;
    localparam logic [3:0] OP_REVERSE    = 4'd7;
    localparam logic [3:0] OP_CLEAR      = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] data;
        logic [7:0]         position;
        logic [1:0]         status;
        logic [8:0]         occupancy;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
        logic scan;
    } t_cmd;

    typedef struct packed {
        logic needs_read;
        logic needs_scan;
        logic hit;
        logic last;
    } t_sts;

endpackage

// ===== rtl/deqs_datapath.sv =====
// deqs_datapath: ring store, head/tail pointers, count, orientation flag,
// search walker and response registers
// depends on deqs_pkg
module deqs_datapath #(
    parameter int DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  deqs_pkg::t_req i_req,
    input  deqs_pkg::t_cmd i_cmd,
    output deqs_pkg::t_sts o_sts,
    output deqs_pkg::t_rsp o_rsp
);
    import deqs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : PW'(p - 1'b1);
    endfunction

    logic [3:0]         r_op,   n_op;
    logic signed [31:0] r_val,  n_val;
    logic [PW-1:0]      r_head, n_head;
    logic [PW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic               r_rev,  n_rev;
    logic [PW-1:0]      r_scan, n_scan;
    logic [CW-1:0]      r_idx,  n_idx;
    logic [CW-1:0]      r_pos,  n_pos;
    logic signed [31:0] r_data, n_data;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_rd_data;

    logic signed [31:0] mem [DEPTH];
    logic               mem_we;
    logic               mem_re;
    logic [PW-1:0]      waddr;
    logic [PW-1:0]      raddr;

    logic          is_back;
    logic          tail_side;
    logic          full;
    logic          empty;
    logic [PW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [PW-1:0] scan_start, scan_next;
    logic          last;
    logic          hit;
    logic [CW+7:0] pos_ext;
    logic [CW+8:0] occ_ext;

    assign is_back   = (r_op == OP_PUSH_BACK) || (r_op == OP_POP_BACK) ||
                       (r_op == OP_PEEK_BACK);
    assign tail_side = is_back ^ r_rev;
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign head_inc  = ptr_inc(r_head);
    assign head_dec  = ptr_dec(r_head);
    assign tail_inc  = ptr_inc(r_tail);
    assign tail_dec  = ptr_dec(r_tail);
    assign scan_start = r_rev ? tail_dec : r_head;
    assign scan_next  = r_rev ? ptr_dec(r_scan) : ptr_inc(r_scan);
    assign last      = (CW'(r_idx + 1'b1) == r_count);
    assign hit       = (r_rd_data == r_val);

    always_comb begin
        n_op     = r_op;
        n_val    = r_val;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_rev    = r_rev;
        n_scan   = r_scan;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_data   = r_data;
        n_status = r_status;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        waddr    = r_tail;
        raddr    = r_head;

        if (i_cmd.load) begin
            n_op  = i_req.opcode;
            n_val = i_req.value;
        end

        if (i_cmd.exec) begin
            n_data   = '0;
            n_pos    = '0;
            n_status = ST_OK;
            case (r_op)
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                        if (tail_side) begin
                            waddr  = r_tail;
                            n_tail = tail_inc;
                        end else begin
                            waddr  = head_dec;
                            n_head = head_dec;
                        end
                    end
                end
                OP_POP_BACK, OP_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        mem_re  = 1'b1;
                        n_count = CW'(r_count - 1'b1);
                        if (tail_side) begin
                            raddr  = tail_dec;
                            n_tail = tail_dec;
                        end else begin
                            raddr  = r_head;
                            n_head = head_inc;
                        end
                    end
                end
                OP_PEEK_BACK, OP_PEEK_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        mem_re = 1'b1;
                        raddr  = tail_side ? tail_dec : r_head;
                    end
                end
                OP_SEARCH: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        mem_re   = 1'b1;
                        raddr    = scan_start;
                        n_scan   = scan_start;
                        n_idx    = '0;
                    end
                end
                OP_REVERSE: begin
                    n_rev = ~r_rev;
                end
                OP_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    n_rev   = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.capture) begin
            n_data = r_rd_data;
        end

        if (i_cmd.scan) begin
            if (hit) begin
                n_status = ST_OK;
                n_pos    = r_idx;
            end else if (!last) begin
                n_idx  = CW'(r_idx + 1'b1);
                mem_re = 1'b1;
                raddr  = scan_next;
                n_scan = scan_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_scan   <= n_scan;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_data   <= n_data;
        r_status <= n_status;
    end

    // ring store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= r_val;
        end
        if (mem_re) begin
            r_rd_data <= mem[raddr];
        end
    end

    assign pos_ext = {8'b0, r_pos};
    assign occ_ext = {9'b0, r_count};

    assign o_sts.needs_read = !empty && ((r_op == OP_POP_BACK) || (r_op == OP_POP_FRONT) ||
                              (r_op == OP_PEEK_BACK) || (r_op == OP_PEEK_FRONT));
    assign o_sts.needs_scan = !empty && (r_op == OP_SEARCH);
    assign o_sts.hit        = hit;
    assign o_sts.last       = last;

    assign o_rsp.data      = r_data;
    assign o_rsp.position  = pos_ext[7:0];
    assign o_rsp.status    = r_status;
    assign o_rsp.occupancy = occ_ext[8:0];

endmodule

// ===== rtl/deqs_ctrl.sv =====
// deqs_ctrl: sequencing state machine for the deque with search
// drives request and response handshakes and datapath commands; depends on deqs_pkg
module deqs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    input  deqs_pkg::t_sts i_sts,
    output deqs_pkg::t_cmd o_cmd
);
    import deqs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_READ = 5'b00100,
        S_SCAN = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.needs_read)      n_state = S_READ;
                else if (i_sts.needs_scan) n_state = S_SCAN;
                else                       n_state = S_OUT;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_SCAN: begin
                if (i_sts.hit || i_sts.last) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_rsp_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_stall   = (r_state != S_IDLE);
    assign o_rsp_valid   = (r_state == S_OUT);
    assign o_cmd.load    = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.capture = (r_state == S_READ);
    assign o_cmd.scan    = (r_state == S_SCAN);

endmodule

// ===== rtl/double_ended_queue_with_search_core.sv =====
// request accept to response valid: an execute step, then the response for push,
// reverse, clear and any full or empty case; pop and peek add a registered read;
// a search adds one scan step per entry examined, up to the entry count
// one request at a time; the next is taken the cycle after the response is taken
// reset is synchronous active low and clears pointers, count, flag and state;
// store contents are not cleared and no clearing pass runs
module double_ended_queue_with_search_core #(
    parameter int DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  deqs_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output deqs_pkg::t_rsp o_rsp
);
    import deqs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    deqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    deqs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== rtl/deqs_checker.sv =====
// deqs_port_checker: port-level checks for the deque with search core
// bound to double_ended_queue_with_search_core; depends on deqs_pkg
module deqs_port_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_stall,
    input deqs_pkg::t_req i_req,
    input logic           o_rsp_valid,
    input logic           i_rsp_stall,
    input deqs_pkg::t_rsp o_rsp
);
    import deqs_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid)
        else $error("response dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_req_stall)
        else $error("request taken while a response is pending");

    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> !o_rsp_valid)
        else $error("response in the cycle after accept");

    a_empty_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_EMPTY) |->
            (o_rsp.occupancy == 9'd0) && (o_rsp.data == 32'sd0))
        else $error("empty status with entries or data");

    a_not_found_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_NOT_FOUND) |->
            (o_rsp.position == 8'd0) && (o_rsp.data == 32'sd0))
        else $error("not found status with position or data");

endmodule

bind double_ended_queue_with_search_core deqs_port_checker u_deqs_checker (.*);

// ===== test/deqs_checker.sv =====
// deqs_checker: watches both channels of the deque core, predicts each response
// and compares it field by field; depends on deqs_pkg only
module deqs_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_stall,
    input  deqs_pkg::t_req i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_stall,
    input  deqs_pkg::t_rsp i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import deqs_pkg::*;

    localparam int DEPTH = 256;

    logic [31:0] ring [DEPTH];
    logic [7:0]  head;
    logic [8:0]  count;
    logic        flipped;
    t_rsp        rsp_due [$];
    int          fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [7:0] slot_at(input logic [8:0] idx);
        logic [8:0] s;
        if (flipped) begin
            s = {1'b0, head} + count - 9'd1 - idx;
        end else begin
            s = {1'b0, head} + idx;
        end
        return s[7:0];
    endfunction

    task automatic deque_apply(input t_req r, output t_rsp res);
        logic       back;
        logic       found;
        logic [7:0] idx;
        res.data      = '0;
        res.position  = '0;
        res.status    = ST_OK;
        case (r.opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                back = (r.opcode == OP_PUSH_BACK);
                if (count >= 9'(DEPTH)) begin
                    res.status = ST_FULL;
                end else if (back != flipped) begin
                    idx = head + count[7:0];
                    ring[idx] = r.value;
                    count = count + 9'd1;
                end else begin
                    head = head - 8'd1;
                    ring[head] = r.value;
                    count = count + 9'd1;
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                back = (r.opcode == OP_POP_BACK);
                if (count == 0) begin
                    res.status = ST_EMPTY;
                end else if (back != flipped) begin
                    idx = head + count[7:0] - 8'd1;
                    res.data = ring[idx];
                    count = count - 9'd1;
                end else begin
                    res.data = ring[head];
                    head = head + 8'd1;
                    count = count - 9'd1;
                end
            end
            OP_PEEK_BACK, OP_PEEK_FRONT: begin
                if (count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = ring[slot_at(r.opcode == OP_PEEK_FRONT ? 9'd0 : count - 9'd1)];
                end
            end
            OP_SEARCH: begin
                if (count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    found = 1'b0;
                    res.status = ST_NOT_FOUND;
                    for (int i = 0; i < int'(count); i++) begin
                        if (!found && ring[slot_at(9'(i))] == r.value) begin
                            found = 1'b1;
                            res.status = ST_OK;
                            res.position = 8'(i);
                        end
                    end
                end
            end
            OP_REVERSE: begin
                flipped = ~flipped;
            end
            OP_CLEAR: begin
                count   = '0;
                head    = '0;
                flipped = 1'b0;
            end
            default: begin
            end
        endcase
        res.occupancy = count;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        t_rsp res;
        if (!i_rst_n) begin
            head    = '0;
            count   = '0;
            flipped = 1'b0;
            rsp_due.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (rsp_due.size() == 0) begin
                    $error("response with no request waiting");
                    fails++;
                end else begin
                    want = rsp_due.pop_front();
                    check_field("data", want.data, i_rsp.data);
                    check_field("position", 32'(want.position), 32'(i_rsp.position));
                    check_field("status", 32'(want.status), 32'(i_rsp.status));
                    check_field("occupancy", 32'(want.occupancy), 32'(i_rsp.occupancy));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                deque_apply(i_req, res);
                rsp_due.push_back(res);
            end
        end
        o_fail_count = fails;
        o_pending    = rsp_due.size();
    end

endmodule

// ===== test/tb_double_ended_queue_with_search_core.sv =====
// tb_double_ended_queue_with_search_core: drives requests into the deque core
// with bursts, gaps and response stalls; checking lives in deqs_checker
// depends on deqs_pkg, deqs_checker and double_ended_queue_with_search_core
module tb_double_ended_queue_with_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    import deqs_pkg::*;

    localparam logic [31:0] INT_MIN         = 32'h8000_0000;
    localparam logic [31:0] INT_MAX         = 32'h7fff_ffff;
    localparam logic [3:0]  OP_FIRST_UNUSED = 4'd9;
    localparam logic [3:0]  OP_LAST_UNUSED  = 4'd15;
    localparam int          ITEM_TARGET     = 1900;
    localparam int          LIMIT           = 4_000_000;

    logic  i_clk;
    logic  i_rst_n;
    logic  req_valid;
    logic  req_stall;
    t_req  req;
    logic  rsp_valid;
    logic  rsp_stall;
    t_rsp  rsp;
    int    fail_count;
    int    pending;
    int    cycle_count = 0;
    int    sent = 0;
    int    burst_left = 0;
    logic [31:0] pool [8];

    double_ended_queue_with_search_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    deqs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        i_rst_n   = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
    end

    task automatic send_req(input logic [3:0] op, input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_valid  = 1'b1;
        req.opcode = op;
        req.value  = val;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 1) == 0) begin
            return pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_opcode(input int push_pct, input int pop_pct);
        int   r;
        logic e;
        r = $urandom_range(0, 99);
        e = 1'($urandom_range(0, 1));
        if (r < push_pct) begin
            return e ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end
        if (r < push_pct + pop_pct) begin
            return e ? OP_POP_BACK : OP_POP_FRONT;
        end
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return e ? OP_PEEK_BACK : OP_PEEK_FRONT;
        end
        if (r < 70) begin
            return OP_SEARCH;
        end
        if (r < 90) begin
            return OP_REVERSE;
        end
        return 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    endfunction

    task automatic run_phase(input int n, input int push_pct, input int pop_pct);
        repeat (n) send_req(pick_opcode(push_pct, pop_pct), pick_value());
    endtask

    // receiver stall pattern, with one long hold-off to back up the request side
    initial begin : rsp_side
        int seg_len;
        int mode;
        int seg_count;
        int tick;
        seg_count = 0;
        tick = 0;
        @(posedge i_rst_n);
        forever begin
            seg_count++;
            if (seg_count == 6) begin
                @(negedge i_clk);
                rsp_stall = 1'b1;
                repeat (600) @(negedge i_clk);
                rsp_stall = 1'b0;
            end else begin
                seg_len = $urandom_range(10, 120);
                mode    = $urandom_range(0, 3);
                repeat (seg_len) begin
                    @(negedge i_clk);
                    tick++;
                    case (mode)
                        0: rsp_stall = 1'b0;
                        1: rsp_stall = ($urandom_range(0, 3) == 0);
                        2: rsp_stall = 1'($urandom_range(0, 1));
                        default: rsp_stall = ((tick % 7) < 3);
                    endcase
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int phase;
        pool[0] = INT_MIN;
        pool[1] = INT_MAX;
        pool[2] = '0;
        pool[3] = '1;
        for (int i = 4; i < 8; i++) pool[i] = $urandom;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: value extremes, both ends, empty cases, unused codes
        send_req(OP_PUSH_BACK, INT_MIN);
        send_req(OP_PUSH_FRONT, INT_MAX);
        send_req(OP_PUSH_BACK, '0);
        send_req(OP_PUSH_FRONT, '1);
        send_req(OP_PEEK_BACK, '0);
        send_req(OP_PEEK_FRONT, '0);
        send_req(OP_SEARCH, '1);
        send_req(OP_SEARCH, INT_MIN);
        send_req(OP_SEARCH, 32'h1234_5678);
        send_req(OP_REVERSE, '0);
        send_req(OP_PEEK_FRONT, '0);
        send_req(OP_SEARCH, INT_MAX);
        send_req(OP_POP_FRONT, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_FRONT, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_FRONT, '0);
        send_req(OP_PEEK_BACK, '0);
        send_req(OP_PEEK_FRONT, '0);
        send_req(OP_SEARCH, '0);
        send_req(OP_REVERSE, '1);
        send_req(OP_PUSH_FRONT, 32'h5a5a_a5a5);
        send_req(OP_CLEAR, '1);
        send_req(OP_FIRST_UNUSED, '1);
        send_req(OP_LAST_UNUSED, INT_MIN);

        // fill past full from empty
        run_phase(300, 95, 0);

        while (sent < ITEM_TARGET) begin
            phase = $urandom_range(0, 9);
            case (phase)
                0, 1, 2, 3: run_phase($urandom_range(10, 60), 36, 24);
                4, 5:       run_phase($urandom_range(40, 290), 95, 0);
                6, 7:       run_phase($urandom_range(40, 290), 0, 90);
                8: begin
                    repeat ($urandom_range(5, 15)) send_req(4'($urandom_range(0, 15)), $urandom);
                end
                default:    send_req(OP_CLEAR, $urandom);
            endcase
        end

        req_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/deqs_pkg.sv
rtl/deqs_datapath.sv
rtl/deqs_ctrl.sv
rtl/double_ended_queue_with_search_core.sv
rtl/deqs_checker.sv
test/deqs_checker.sv
test/tb_double_ended_queue_with_search_core.sv
